// ===== rtl/csalu_pkg.sv =====
// ----------------------------------------------------------------------------
// csalu_pkg
// Types, opcodes and the microprogram of the circular stack ALU.
// ----------------------------------------------------------------------------
package csalu_pkg;

  typedef enum logic [3:0] {
    M_PUSH      = 4'd0,
    M_DUP       = 4'd1,
    M_DROP      = 4'd2,
    M_BACK      = 4'd3,
    M_SWAP      = 4'd4,
    M_OVER      = 4'd5,
    M_ADD       = 4'd6,
    M_AND       = 4'd7,
    M_OR        = 4'd8,
    M_XOR       = 4'd9,
    M_INVERT    = 4'd10,
    M_NEGATE    = 4'd11,
    M_PRINT     = 4'd12,
    M_PRINT_ALL = 4'd13,
    M_SET_SPEED = 4'd14,
    M_NOP       = 4'd15
  } mode_t;

  // ring address relative to the top index
  typedef enum logic [1:0] {
    AT_TOP,
    AT_UP,
    AT_DOWN
  } at_t;

  // word source for RAM writes and for the emitted value
  typedef enum logic [2:0] {
    S_LIT,
    S_RD,
    S_A,
    S_B,
    S_ALU
  } src_t;

  typedef enum logic [1:0] {
    P_KEEP,
    P_INC,
    P_DEC
  } ptr_t;

  typedef struct packed {
    logic rd;
    at_t  rd_at;
    logic wr;
    at_t  wr_at;
    src_t src;
    logic ld_a;
    logic ld_b;
    logic ld_spd;
    ptr_t ptr;
    logic emit;
    logic printed;
    logic fin;
    logic loop;
  } ctrl_t;

  typedef struct packed {
    logic  last;
    ctrl_t cw;
  } ucode_t;

  typedef logic [4:0] pc_t;

  localparam logic [7:0] SPEED_RESET = 8'd15;

  localparam ctrl_t CW_IDLE = '{
    rd: 1'b0, rd_at: AT_TOP, wr: 1'b0, wr_at: AT_TOP, src: S_RD,
    ld_a: 1'b0, ld_b: 1'b0, ld_spd: 1'b0, ptr: P_KEEP,
    emit: 1'b0, printed: 1'b0, fin: 1'b0, loop: 1'b0
  };

  // program entry points
  localparam pc_t UC_PUSH  = 5'd0;
  localparam pc_t UC_DUP   = 5'd1;
  localparam pc_t UC_DROP  = 5'd3;
  localparam pc_t UC_BACK  = 5'd5;
  localparam pc_t UC_SWAP  = 5'd7;
  localparam pc_t UC_OVER  = 5'd11;
  localparam pc_t UC_BIN   = 5'd13;
  localparam pc_t UC_UNARY = 5'd16;
  localparam pc_t UC_PRINT = 5'd18;
  localparam pc_t UC_PALL  = 5'd20;
  localparam pc_t UC_SPEED = 5'd22;
  localparam pc_t UC_NOP   = 5'd25;

  function automatic pc_t entry(mode_t m);
    pc_t p;
    p = UC_NOP;
    unique case (m) inside
      M_PUSH:                       p = UC_PUSH;
      M_DUP:                        p = UC_DUP;
      M_DROP:                       p = UC_DROP;
      M_BACK:                       p = UC_BACK;
      M_SWAP:                       p = UC_SWAP;
      M_OVER:                       p = UC_OVER;
      M_ADD, M_AND, M_OR, M_XOR:    p = UC_BIN;
      M_INVERT, M_NEGATE:           p = UC_UNARY;
      M_PRINT:                      p = UC_PRINT;
      M_PRINT_ALL:                  p = UC_PALL;
      M_SET_SPEED:                  p = UC_SPEED;
      M_NOP:                        p = UC_NOP;
    endcase
    return p;
  endfunction

  // Microprogram. Read data is available in the step after the read is issued.
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t c;
    c = CW_IDLE;
    unique case (pc)
      UC_PUSH: begin
        c.wr = 1'b1; c.wr_at = AT_UP; c.src = S_LIT; c.ptr = P_INC;
        c.emit = 1'b1; c.fin = 1'b1;
      end
      UC_DUP: begin
        c.rd = 1'b1; c.rd_at = AT_TOP;
      end
      UC_DUP + 5'd1: begin
        c.wr = 1'b1; c.wr_at = AT_UP; c.src = S_RD; c.ptr = P_INC;
        c.emit = 1'b1; c.fin = 1'b1;
      end
      UC_DROP: begin
        c.rd = 1'b1; c.rd_at = AT_DOWN; c.ptr = P_DEC;
      end
      UC_DROP + 5'd1: begin
        c.src = S_RD; c.emit = 1'b1; c.fin = 1'b1;
      end
      UC_BACK: begin
        c.rd = 1'b1; c.rd_at = AT_UP; c.ptr = P_INC;
      end
      UC_BACK + 5'd1: begin
        c.src = S_RD; c.emit = 1'b1; c.fin = 1'b1;
      end
      UC_SWAP: begin
        c.rd = 1'b1; c.rd_at = AT_TOP;
      end
      UC_SWAP + 5'd1: begin
        c.ld_a = 1'b1; c.rd = 1'b1; c.rd_at = AT_DOWN;
      end
      UC_SWAP + 5'd2: begin
        c.ld_b = 1'b1; c.wr = 1'b1; c.wr_at = AT_DOWN; c.src = S_A;
      end
      UC_SWAP + 5'd3: begin
        c.wr = 1'b1; c.wr_at = AT_TOP; c.src = S_B; c.emit = 1'b1; c.fin = 1'b1;
      end
      UC_OVER: begin
        c.rd = 1'b1; c.rd_at = AT_DOWN;
      end
      UC_OVER + 5'd1: begin
        c.wr = 1'b1; c.wr_at = AT_UP; c.src = S_RD; c.ptr = P_INC;
        c.emit = 1'b1; c.fin = 1'b1;
      end
      UC_BIN: begin
        c.rd = 1'b1; c.rd_at = AT_TOP;
      end
      UC_BIN + 5'd1: begin
        c.ld_a = 1'b1; c.rd = 1'b1; c.rd_at = AT_DOWN;
      end
      UC_BIN + 5'd2: begin
        c.wr = 1'b1; c.wr_at = AT_DOWN; c.src = S_ALU; c.ptr = P_DEC;
        c.emit = 1'b1; c.fin = 1'b1;
      end
      UC_UNARY: begin
        c.rd = 1'b1; c.rd_at = AT_TOP;
      end
      UC_UNARY + 5'd1: begin
        c.wr = 1'b1; c.wr_at = AT_TOP; c.src = S_ALU; c.emit = 1'b1; c.fin = 1'b1;
      end
      UC_PRINT: begin
        c.rd = 1'b1; c.rd_at = AT_TOP; c.ptr = P_DEC;
      end
      UC_PRINT + 5'd1: begin
        c.src = S_RD; c.emit = 1'b1; c.printed = 1'b1; c.fin = 1'b1;
      end
      UC_PALL: begin
        c.rd = 1'b1; c.rd_at = AT_TOP; c.ptr = P_DEC;
      end
      UC_PALL + 5'd1: begin
        // emits the previous read and fetches the next word until the count ends
        c.rd = 1'b1; c.rd_at = AT_TOP; c.ptr = P_DEC; c.src = S_RD;
        c.emit = 1'b1; c.printed = 1'b1; c.fin = 1'b1; c.loop = 1'b1;
      end
      UC_SPEED: begin
        c.rd = 1'b1; c.rd_at = AT_TOP;
      end
      UC_SPEED + 5'd1: begin
        c.ld_spd = 1'b1; c.rd = 1'b1; c.rd_at = AT_DOWN; c.ptr = P_DEC;
      end
      UC_SPEED + 5'd2: begin
        c.src = S_RD; c.emit = 1'b1; c.fin = 1'b1;
      end
      UC_NOP: begin
        c.rd = 1'b1; c.rd_at = AT_TOP;
      end
      UC_NOP + 5'd1: begin
        c.src = S_RD; c.emit = 1'b1; c.fin = 1'b1;
      end
      default: begin
        c.fin = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/csalu_if.sv =====
// ----------------------------------------------------------------------------
// csalu_if
// Valid/ready channels for commands and results of the circular stack ALU.
// ----------------------------------------------------------------------------
interface csalu_cmd_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  mode;
  logic signed [15:0] literal;

  modport source (output valid, output mode, output literal, input ready);
  modport sink (input valid, input mode, input literal, output ready);
endinterface

interface csalu_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;
  logic               printed;
  logic               last;
  logic        [7:0]  speed_now;

  modport source (output valid, output value, output printed, output last,
                  output speed_now, input ready);
  modport sink (input valid, input value, input printed, input last,
                input speed_now, output ready);
endinterface

// ===== rtl/csalu_ram.sv =====
// ----------------------------------------------------------------------------
// csalu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csalu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/csalu_seq.sv =====
// ----------------------------------------------------------------------------
// csalu_seq
// Microprogram sequencer: step counter, loop count and control word fetch.
// ----------------------------------------------------------------------------
module csalu_seq #(
  parameter int STACK_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  csalu_pkg::mode_t mode,
  input  logic             stall,
  output logic             busy,
  output csalu_pkg::mode_t mode_q,
  output csalu_pkg::ucode_t uc
);
  import csalu_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STACK_DEPTH - 1);

  pc_t              pc;
  logic [CNT_W-1:0] cnt;
  ctrl_t            raw;
  ctrl_t            cw;
  logic             go;
  logic             cnt_done;
  logic             hold_loop;

  always_comb begin
    raw       = ucode(pc);
    cnt_done  = (cnt == CNT_LAST);
    hold_loop = raw.loop && !cnt_done;
    // a step that emits waits while the output register is full and not being taken
    go        = busy && !(raw.emit && stall);
    cw        = raw;
    if (!go) begin
      cw = CW_IDLE;
    end else if (raw.loop && cnt_done) begin
      cw.ptr = P_KEEP;
    end
    uc.cw   = cw;
    uc.last = raw.fin && !hold_loop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= UC_PUSH;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= entry(mode);
      cnt  <= '0;
    end else if (go) begin
      if (raw.fin) begin
        if (hold_loop) begin
          cnt <= cnt + 1'b1;
        end else begin
          busy <= 1'b0;
        end
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_q <= mode;
    end
  end

endmodule

// ===== rtl/csalu_dp.sv =====
// ----------------------------------------------------------------------------
// csalu_dp
// Datapath: ring RAM with valid bits, top index, operand registers, ALU
// and speed register.
// ----------------------------------------------------------------------------
module csalu_dp #(
  parameter int STACK_DEPTH = 8,
  parameter int WORD_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] literal,
  input  csalu_pkg::mode_t   mode,
  input  csalu_pkg::ctrl_t   cw,
  output logic signed [15:0] value,
  output logic        [7:0]  speed
);
  import csalu_pkg::*;

  localparam int PW = $clog2(STACK_DEPTH);
  localparam logic [PW-1:0] IDX_LAST = PW'(STACK_DEPTH - 1);

  logic [PW-1:0]          tp;
  logic [PW-1:0]          tp_up;
  logic [PW-1:0]          tp_down;
  logic [PW-1:0]          raddr;
  logic [PW-1:0]          waddr;
  logic [STACK_DEPTH-1:0] vld;
  logic                   rd_vld;
  logic [WORD_BITS-1:0]   q;
  logic [WORD_BITS-1:0]   rdw;
  logic [WORD_BITS-1:0]   a;
  logic [WORD_BITS-1:0]   b;
  logic [WORD_BITS-1:0]   lit_w;
  logic [WORD_BITS-1:0]   alu;
  logic [WORD_BITS-1:0]   src_w;
  logic [WORD_BITS+15:0]  lit_ext;
  logic [WORD_BITS+15:0]  val_ext;

  function automatic logic [PW-1:0] pick(at_t at, logic [PW-1:0] t,
                                          logic [PW-1:0] u, logic [PW-1:0] d);
    logic [PW-1:0] r;
    r = t;
    unique case (at)
      AT_TOP:  r = t;
      AT_UP:   r = u;
      AT_DOWN: r = d;
      default: r = t;
    endcase
    return r;
  endfunction

  always_comb begin
    tp_up   = (tp == IDX_LAST) ? '0 : tp + 1'b1;
    tp_down = (tp == '0) ? IDX_LAST : tp - 1'b1;
    raddr   = pick(cw.rd_at, tp, tp_up, tp_down);
    waddr   = pick(cw.wr_at, tp, tp_up, tp_down);
    // never-written entries read as the reset value, zero
    rdw     = rd_vld ? q : '0;
    lit_ext = {{WORD_BITS{literal[15]}}, literal};
  end

  always_comb begin
    case (mode)
      M_ADD:    alu = a + rdw;
      M_AND:    alu = a & rdw;
      M_OR:     alu = a | rdw;
      M_XOR:    alu = a ^ rdw;
      M_INVERT: alu = ~rdw;
      M_NEGATE: alu = '0 - rdw;
      default:  alu = rdw;
    endcase
  end

  always_comb begin
    unique case (cw.src)
      S_LIT:   src_w = lit_w;
      S_RD:    src_w = rdw;
      S_A:     src_w = a;
      S_B:     src_w = b;
      S_ALU:   src_w = alu;
      default: src_w = rdw;
    endcase
    val_ext = {16'b0, src_w};
    value   = val_ext[15:0];
  end

  csalu_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cw.wr),
    .waddr (waddr),
    .wdata (src_w),
    .re    (cw.rd),
    .raddr (raddr),
    .rdata (q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tp    <= '0;
      vld   <= '0;
      speed <= SPEED_RESET;
    end else begin
      case (cw.ptr)
        P_INC:   tp <= tp_up;
        P_DEC:   tp <= tp_down;
        default: tp <= tp;
      endcase
      if (cw.wr) begin
        vld[waddr] <= 1'b1;
      end
      if (cw.ld_spd) begin
        speed <= rdw[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.rd) begin
      rd_vld <= vld[raddr];
    end
    if (cw.ld_a) begin
      a <= rdw;
    end
    if (cw.ld_b) begin
      b <= rdw;
    end
    if (start) begin
      lit_w <= lit_ext[WORD_BITS-1:0];
    end
  end

endmodule

// ===== rtl/circular_stack_alu.sv =====
// ----------------------------------------------------------------------------
// circular_stack_alu
// Forth-style data stack in a wrapping ring with a small ALU, run by a
// microprogram over a single-port-read RAM.
// ----------------------------------------------------------------------------
// Steps per command (at most one RAM read issued per step, data used the next step):
//   push 1, dup/drop/back/over/invert/negate/print/nop 2, add/and/or/xor and
//   set_speed 3, swap 4, print_all 1 + STACK_DEPTH (one result per loop step unless stalled).
// A new command is accepted the cycle after the last step.
// Results are registered; a full output register that is not being taken stalls only emitting steps.
// Reset clears the state: ring reads zero (per-entry valid bits), top 0, speed 15.
module circular_stack_alu #(
  parameter int STACK_DEPTH = 8,
  parameter int WORD_BITS   = 16
) (
  input logic        clk,
  input logic        rst,
  csalu_cmd_if.sink  cmd,
  csalu_res_if.source res
);
  import csalu_pkg::*;

  logic               busy;
  logic               start;
  logic               stall;
  mode_t              mode_q;
  ucode_t             uc;
  logic signed [15:0] dp_value;
  logic        [7:0]  speed;

  logic               out_valid;
  logic signed [15:0] out_value;
  logic               out_printed;
  logic               out_last;
  logic        [7:0]  out_speed;

  assign cmd.ready = !busy;
  assign start     = cmd.valid && !busy;
  assign stall     = out_valid && !res.ready;

  csalu_seq #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode_t'(cmd.mode)),
    .stall  (stall),
    .busy   (busy),
    .mode_q (mode_q),
    .uc     (uc)
  );

  csalu_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .literal (cmd.literal),
    .mode    (mode_q),
    .cw      (uc.cw),
    .value   (dp_value),
    .speed   (speed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uc.cw.emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.cw.emit) begin
      out_value   <= dp_value;
      out_printed <= uc.cw.printed;
      out_last    <= uc.last;
      out_speed   <= speed;
    end
  end

  assign res.valid     = out_valid;
  assign res.value     = out_value;
  assign res.printed   = out_printed;
  assign res.last      = out_last;
  assign res.speed_now = out_speed;

endmodule

// ===== rtl/csalu_chk.sv =====
// ----------------------------------------------------------------------------
// csalu_chk
// Port-level checks for the circular stack ALU, bound to the top level.
// ----------------------------------------------------------------------------
module csalu_chk (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] value,
  input logic        printed,
  input logic        last
);

  // a stalled result holds its contents
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(value) && $stable(last)
                                && $stable(printed))
    else $error("result changed while stalled");

  // every command runs at least one step before the next is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted back to back");

  // only a print-all transaction produces more than one result
  a_plain_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !printed |-> last)
    else $error("non-printed result not marked last");

  // mid print-all the command side stays closed
  a_busy_mid_burst: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> !cmd_ready)
    else $error("command ready during a multi-result transaction");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind circular_stack_alu csalu_chk u_csalu_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .value     (res.value),
  .printed   (res.printed),
  .last      (res.last)
);
